### src/signed_count_rle_decoder_defines.svh
// Assertion macros shared by the decoder files.
`ifndef SIGNED_COUNT_RLE_DECODER_DEFINES_SVH
`define SIGNED_COUNT_RLE_DECODER_DEFINES_SVH

`ifndef NO_ASSERTIONS
// Check a property on every clock edge outside reset.
`define RLED_ASSERT(lbl, clk, rstn, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!(rstn)) (prop)) else $error(msg);
// Check that a condition implies a consequence on the following edge.
`define RLED_ASSERT_NEXT(lbl, clk, rstn, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |=> (cons)) \
        else $error(msg);
`else
`define RLED_ASSERT(lbl, clk, rstn, prop, msg)
`define RLED_ASSERT_NEXT(lbl, clk, rstn, ante, cons, msg)
`endif

`endif

### src/rled_pkg.sv
`timescale 1ns / 1ps
`default_nettype none

package rled_pkg;

    localparam int unsigned BYTE_W  = 8;
    localparam int unsigned RUN_W   = 7;   // repeat count 1..127
    localparam int unsigned CNT_W   = 2;
    localparam int unsigned M_DATA_W = 24; // first, second, count, zero fill

    // One unit of work for the back end: a byte and how many copies of it.
    typedef struct packed {
        logic [BYTE_W-1:0] data;
        logic [RUN_W-1:0]  count;
    } rled_job_t;

endpackage

`default_nettype wire

### src/rled_front.sv
`timescale 1ns / 1ps
`default_nettype none

module rled_front
    import rled_pkg::*;
(
    input  wire logic              aclk,
    input  wire logic              aresetn,
    input  wire logic              s_tvalid,
    output logic                   s_tready,
    input  wire logic [BYTE_W-1:0] s_tdata,    // [7:0] in_byte
    input  wire logic              job_ready,
    output logic                   job_push,
    output rled_job_t              job
);

    typedef enum logic [1:0] {
        MODE_HEADER  = 2'd0,
        MODE_REPEAT  = 2'd1,
        MODE_LITERAL = 2'd2
    } mode_t;

    mode_t             mode_reg, mode_next;
    logic [BYTE_W-1:0] remaining_reg, remaining_next;
    logic              accept;

    assign s_tready = job_ready;
    assign accept   = s_tvalid && s_tready;

    // Classify the byte and build the job for the back end
    always_comb begin
        mode_next      = mode_reg;
        remaining_next = remaining_reg;
        job_push       = 1'b0;
        job.data       = s_tdata;
        job.count      = RUN_W'(1);
        case (mode_reg)
            MODE_REPEAT: begin
                job_push  = accept;
                job.count = remaining_reg[RUN_W-1:0];
                if (accept) begin
                    mode_next      = MODE_HEADER;
                    remaining_next = '0;
                end
            end
            MODE_LITERAL: begin
                job_push = accept;
                if (accept) begin
                    remaining_next = remaining_reg - 1'b1;
                    if (remaining_reg == BYTE_W'(1)) begin
                        mode_next = MODE_HEADER;
                    end
                end
            end
            default: begin
                if (accept) begin
                    if (s_tdata == '0) begin
                        mode_next      = MODE_HEADER;
                        remaining_next = '0;
                    end else if (!s_tdata[BYTE_W-1]) begin
                        mode_next      = MODE_REPEAT;
                        remaining_next = s_tdata;
                    end else begin
                        // negated header gives 1..128 literal bytes
                        mode_next      = MODE_LITERAL;
                        remaining_next = BYTE_W'(~s_tdata + 1'b1);
                    end
                end
            end
        endcase
    end

    // Hold decode state
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            mode_reg      <= MODE_HEADER;
            remaining_reg <= '0;
        end else begin
            mode_reg      <= mode_next;
            remaining_reg <= remaining_next;
        end
    end

endmodule

`default_nettype wire

### src/rled_fifo.sv
`timescale 1ns / 1ps
`default_nettype none

module rled_fifo
    import rled_pkg::*;
#(
    parameter int unsigned DEPTH = 2
) (
    input  wire logic      aclk,
    input  wire logic      aresetn,
    input  wire logic      push,
    input  wire rled_job_t push_job,
    output logic           push_ready,
    input  wire logic      pop,
    output logic           pop_valid,
    output rled_job_t      pop_job
);

    localparam int unsigned ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int unsigned FILL_W = $clog2(DEPTH + 1);

    rled_job_t         slots [DEPTH];
    logic [ADDR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [ADDR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [FILL_W-1:0] fill_reg, fill_next;
    logic              do_push, do_pop;

    assign push_ready = (fill_reg != FILL_W'(DEPTH));
    assign pop_valid  = (fill_reg != '0);
    assign pop_job    = slots[rd_ptr_reg];
    assign do_push    = push && push_ready;
    assign do_pop     = pop && pop_valid;

    // Advance pointers with wrap at the queue depth
    always_comb begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        fill_next   = fill_reg;
        if (do_push) begin
            wr_ptr_next = (wr_ptr_reg == ADDR_W'(DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (do_pop) begin
            rd_ptr_next = (rd_ptr_reg == ADDR_W'(DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (do_push && !do_pop) begin
            fill_next = fill_reg + 1'b1;
        end else if (do_pop && !do_push) begin
            fill_next = fill_reg - 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            fill_reg   <= '0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            fill_reg   <= fill_next;
        end
    end

    // Store job payload
    always_ff @(posedge aclk) begin
        if (do_push) begin
            slots[wr_ptr_reg] <= push_job;
        end
    end

endmodule

`default_nettype wire

### src/rled_back.sv
`timescale 1ns / 1ps
`default_nettype none

module rled_back
    import rled_pkg::*;
(
    input  wire logic                aclk,
    input  wire logic                aresetn,
    input  wire logic                job_valid,
    input  wire rled_job_t           job,
    output logic                     job_pop,
    output logic                     m_tvalid,
    input  wire logic                m_tready,
    output logic [M_DATA_W-1:0]      m_tdata,   // [7:0] out_first, [15:8] out_second,
                                                // [17:16] out_count, rest zero
    output logic                     m_tlast    // last_of_item
);

    logic              busy_reg, busy_next;
    logic [BYTE_W-1:0] data_reg, data_next;
    logic [RUN_W-1:0]  left_reg, left_next;
    logic              out_valid_reg, out_valid_next;
    logic [BYTE_W-1:0] out_first_reg, out_first_next;
    logic [BYTE_W-1:0] out_second_reg, out_second_next;
    logic [CNT_W-1:0]  out_count_reg, out_count_next;
    logic              out_last_reg, out_last_next;
    logic              out_free, emit, pair;
    logic [RUN_W-1:0]  left_after;

    assign out_free   = !out_valid_reg || m_tready;
    assign emit       = busy_reg && out_free;
    assign job_pop    = !busy_reg && job_valid;
    assign pair       = |left_reg[RUN_W-1:1];
    assign left_after = left_reg - (pair ? RUN_W'(2) : RUN_W'(1));

    // Load a job, then drain it up to two bytes per result
    always_comb begin
        busy_next       = busy_reg;
        data_next       = data_reg;
        left_next       = left_reg;
        out_valid_next  = out_valid_reg;
        out_first_next  = out_first_reg;
        out_second_next = out_second_reg;
        out_count_next  = out_count_reg;
        out_last_next   = out_last_reg;
        if (job_pop) begin
            busy_next = 1'b1;
            data_next = job.data;
            left_next = job.count;
        end
        if (emit) begin
            out_valid_next  = 1'b1;
            out_first_next  = data_reg;
            out_second_next = pair ? data_reg : '0;
            out_count_next  = pair ? CNT_W'(2) : CNT_W'(1);
            out_last_next   = (left_after == '0);
            left_next       = left_after;
            if (left_after == '0) begin
                busy_next = 1'b0;
            end
        end else if (m_tready) begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg      <= 1'b0;
            out_valid_reg <= 1'b0;
        end else begin
            busy_reg      <= busy_next;
            out_valid_reg <= out_valid_next;
        end
        data_reg       <= data_next;
        left_reg       <= left_next;
        out_first_reg  <= out_first_next;
        out_second_reg <= out_second_next;
        out_count_reg  <= out_count_next;
        out_last_reg   <= out_last_next;
    end

    assign m_tvalid = out_valid_reg;
    assign m_tlast  = out_last_reg;
    assign m_tdata  = {{(M_DATA_W - 2 * BYTE_W - CNT_W){1'b0}},
                       out_count_reg, out_second_reg, out_first_reg};

endmodule

`default_nettype wire

### src/signed_count_rle_decoder.sv
// Channel | Dir | tdata                                  | tuser | tlast
// s_      | in  | [7:0] in_byte                          | -     | -
// m_      | out | [7:0] first, [15:8] second, [17:16] cnt| -     | last_of_item
//
// Header bytes give no result. A literal byte is queued at its transfer, loaded
// by the back end once it is idle and then registered onto m_ when the output
// register is free; the back end loads a new job only after the last result of
// its current job. A repeat of n bytes emits ceil(n/2) results after its load,
// one per cycle while m_tready does not stall, as the output stage hands out up
// to two bytes per result; the front keeps taking bytes meanwhile until the job
// queue (QUEUE_DEPTH entries) fills, and then header bytes wait too.
// Reset is synchronous and active low; m_tready low holds the output register
// and, through the queue, stalls s_tready.
`timescale 1ns / 1ps
`default_nettype none
`include "signed_count_rle_decoder_defines.svh"

module signed_count_rle_decoder
    import rled_pkg::*;
#(
    parameter int unsigned QUEUE_DEPTH = 2
) (
    input  wire logic                aclk,
    input  wire logic                aresetn,
    input  wire logic                s_tvalid,
    output logic                     s_tready,
    input  wire logic [BYTE_W-1:0]   s_tdata,   // [7:0] in_byte
    output logic                     m_tvalid,
    input  wire logic                m_tready,
    output logic [M_DATA_W-1:0]      m_tdata,   // [7:0] out_first, [15:8] out_second,
                                                // [17:16] out_count, rest zero
    output logic                     m_tlast    // last_of_item
);

    rled_job_t front_job, queued_job;
    logic      job_push, job_ready, job_pop, job_valid;

    rled_front u_front (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .job_ready (job_ready),
        .job_push  (job_push),
        .job       (front_job)
    );

    rled_fifo #(
        .DEPTH (QUEUE_DEPTH)
    ) u_fifo (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .push       (job_push),
        .push_job   (front_job),
        .push_ready (job_ready),
        .pop        (job_pop),
        .pop_valid  (job_valid),
        .pop_job    (queued_job)
    );

    rled_back u_back (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .job_valid (job_valid),
        .job       (queued_job),
        .job_pop   (job_pop),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tlast   (m_tlast)
    );

    // A single-byte result always closes its item
    `RLED_ASSERT(a_single_is_last, aclk, aresetn,
        m_tvalid && (m_tdata[17:16] == 2'd1) |-> m_tlast,
        "single-byte result not marked last")
    // Results before the last of an item repeat one byte twice
    `RLED_ASSERT(a_pair_same, aclk, aresetn,
        m_tvalid && !m_tlast |-> (m_tdata[15:8] == m_tdata[7:0]) && (m_tdata[17:16] == 2'd2),
        "non-final result is not a repeated pair")
    // The front never pushes into a full queue
    `RLED_ASSERT(a_no_overflow, aclk, aresetn, job_push |-> job_ready,
        "job pushed into full queue")
    // A result is dropped only after a transfer
    `RLED_ASSERT_NEXT(a_out_hold, aclk, aresetn, m_tvalid && !m_tready,
        m_tvalid && $stable(m_tdata) && $stable(m_tlast), "stalled result changed")

endmodule

`default_nettype wire
